### rtl/hrc_pkg.sv
// shared types, constants and helpers of the hls to rgb converter
package hrc_pkg;

    // fixed point format
    localparam int FRAC_BITS = 12;
    localparam int IN_W      = 24;
    localparam int OUT_W     = 13;

    // internal widths
    localparam int V_W   = FRAC_BITS + 1;           // 0..1.0
    localparam int H_W   = FRAC_BITS + 9;           // hue 0..360 degrees
    localparam int HC_W  = H_W + 2;                 // signed offset hue
    localparam int DH_W  = FRAC_BITS + 6;           // ramp distance, up to 60 degrees
    localparam int DF_W  = FRAC_BITS + 2;           // m2 - m1
    localparam int P_W   = 2 * FRAC_BITS + 3;       // lightness product
    localparam int N_W   = DF_W + DH_W;             // ramp numerator
    localparam int X_W   = FRAC_BITS + 5;           // numerator after the power of two part
    localparam int M_W   = FRAC_BITS + 8;           // reciprocal of 15
    localparam int PR_W  = X_W + M_W;               // reciprocal product
    localparam int Q_W   = FRAC_BITS + 2;           // ramp quotient
    localparam int C_W   = FRAC_BITS + 4;           // signed channel value
    localparam int WR_W  = FRAC_BITS + 14;          // hue wrap candidates

    localparam longint ONE_FX  = longint'(1) <<< FRAC_BITS;
    localparam longint DEG60   = 60 * ONE_FX;
    localparam longint DEG120  = 120 * ONE_FX;
    localparam longint DEG180  = 180 * ONE_FX;
    localparam longint DEG240  = 240 * ONE_FX;
    localparam longint DEG360  = 360 * ONE_FX;
    localparam longint HALF60  = DEG60 / 2;

    // 60 degrees is 15 << (FRAC_BITS + 2): shift, then multiply by 1/15
    localparam int     X_SH    = FRAC_BITS + 2;
    localparam int     RCP_SH  = FRAC_BITS + 11;
    localparam longint RCP_M   = ((longint'(1) <<< RCP_SH) + 14) / 15;

    // number of 360 degree turns the 24 bit hue can span
    localparam int WRAP_N = int'((longint'(1) <<< (IN_W - 1)) / DEG360) + 1;

    // mode codes
    localparam logic [1:0] MODE_RGB = 2'd0;
    localparam logic [1:0] MODE_HLS = 2'd1;
    localparam logic [1:0] MODE_HSL = 2'd2;

    typedef struct packed {
        logic [1:0]             mode;
        logic signed [IN_W-1:0] comp_a;
        logic signed [IN_W-1:0] comp_b;
        logic signed [IN_W-1:0] comp_c;
    } t_hrc_in;

    typedef struct packed {
        logic [OUT_W-1:0] red_out;
        logic [OUT_W-1:0] green_out;
        logic [OUT_W-1:0] blue_out;
    } t_hrc_out;

    // channel segment over the hue circle
    typedef enum logic [1:0] {
        SEG_RAMP,
        SEG_HI,
        SEG_LO
    } t_hrc_seg;

    // clamp a signed value to 0..1.0
    function automatic logic [V_W-1:0] clamp_unit(input logic signed [IN_W-1:0] v);
        logic [V_W-1:0] res;
        if (v < 0) begin
            res = '0;
        end else if (v > ONE_FX) begin
            res = V_W'(ONE_FX);
        end else begin
            res = v[V_W-1:0];
        end
        return res;
    endfunction

endpackage

### rtl/hls_to_rgb_converter_core.sv
// hls to rgb converter: six stage pipeline, one pixel per clock unless stalled
// Takes one pixel per clock while o_ready is high and returns one result per
// pixel, in order, from the output register of the pipe. Mode 0 (and the
// unused mode 3) clamps the three components to 0..1.0 and passes them on;
// mode 1 reads hue, lightness, saturation, mode 2 hue, saturation,
// lightness. Stages: hue wrap and clamps, lightness product, m1/m2, ramp
// products, multiply by 1/15 for the divide by 60 degrees, channel select and
// clamp. Every stage holds its own valid bit and moves whenever the stage
// after it is empty or moving, so empty slots close up under backpressure;
// with i_ready high, o_ready is high. The three multiplier stages (lightness
// product, ramp numerator, reciprocal) set the pipeline depth.
module hls_to_rgb_converter_core
    import hrc_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    output logic     o_ready,
    input  t_hrc_in  i_data,
    output logic     o_valid,
    input  logic     i_ready,
    output t_hrc_out o_data
);

    // stage advance enables, ripple back from the output
    logic w_en1, w_en2, w_en3, w_en4, w_en5, w_en6;

    // valid bits
    logic r_v1, r_v2, r_v3, r_v4, r_v5, r_v6;

    // passthrough (rgb mode or zero saturation) carried down the pipe
    logic           r_s1_pass, r_s2_pass, r_s3_pass, r_s4_pass, r_s5_pass;
    logic [V_W-1:0] r_s1_pv [3];
    logic [V_W-1:0] r_s2_pv [3];
    logic [V_W-1:0] r_s3_pv [3];
    logic [V_W-1:0] r_s4_pv [3];
    logic [V_W-1:0] r_s5_pv [3];

    // stage 1: wrapped hue, clamped lightness and saturation
    logic [H_W-1:0] r_s1_h, n_s1_h;
    logic [V_W-1:0] r_s1_l, n_s1_l;
    logic [V_W-1:0] r_s1_s, n_s1_s;
    logic           n_s1_pass;
    logic [V_W-1:0] n_s1_pv [3];

    // stage 2: lightness product, channel segments
    logic [P_W-1:0] r_s2_p, n_s2_p;
    logic           r_s2_le, n_s2_le;
    logic [V_W-1:0] r_s2_l;
    logic [V_W-1:0] r_s2_s;
    t_hrc_seg       r_s2_seg [3];
    t_hrc_seg       n_s2_seg [3];
    logic [DH_W-1:0] r_s2_dh [3];
    logic [DH_W-1:0] n_s2_dh [3];

    // stage 3: m1, m2 and their distance
    logic signed [C_W-1:0] r_s3_m1, n_s3_m1;
    logic [V_W-1:0]        r_s3_m2, n_s3_m2;
    logic [DF_W-1:0]       r_s3_diff, n_s3_diff;
    t_hrc_seg              r_s3_seg [3];
    logic [DH_W-1:0]       r_s3_dh [3];

    // stage 4: ramp numerators
    logic signed [C_W-1:0] r_s4_m1;
    logic [V_W-1:0]        r_s4_m2;
    t_hrc_seg              r_s4_seg [3];
    logic [N_W-1:0]        r_s4_num [3];

    // stage 5: numerator times 1/15
    logic signed [C_W-1:0] r_s5_m1;
    logic [V_W-1:0]        r_s5_m2;
    t_hrc_seg              r_s5_seg [3];
    logic [PR_W-1:0]       r_s5_prod [3];
    logic [PR_W-1:0]       n_s5_prod [3];

    // stage 6: output register
    t_hrc_out r_out, n_out;

    assign w_en6   = !r_v6 || i_ready;
    assign w_en5   = !r_v5 || w_en6;
    assign w_en4   = !r_v4 || w_en5;
    assign w_en3   = !r_v3 || w_en4;
    assign w_en2   = !r_v2 || w_en3;
    assign w_en1   = !r_v1 || w_en2;
    assign o_ready = w_en1;
    assign o_valid = r_v6;
    assign o_data  = r_out;

    // stage 1: hue wrap into 0..360, component clamps
    always_comb begin
        logic signed [WR_W-1:0] hx;
        logic signed [WR_W-1:0] cand;
        logic signed [WR_W-1:0] hw;
        logic                   hue;
        logic signed [IN_W-1:0] l_raw;
        logic signed [IN_W-1:0] s_raw;
        hx    = WR_W'(i_data.comp_a);
        hw    = hx;
        cand  = '0;
        if (hx < 0) begin
            // negative hue: add turns until it lands in 0..just below 360
            for (int k = 1; k <= WRAP_N; k++) begin
                cand = hx + WR_W'(longint'(k) * DEG360);
                if (cand >= 0 && cand < DEG360) begin
                    hw = cand;
                end
            end
        end else if (hx > DEG360) begin
            // above 360: take off turns until it lands in just above 0..360
            for (int k = 1; k <= WRAP_N; k++) begin
                cand = hx - WR_W'(longint'(k) * DEG360);
                if (cand > 0 && cand <= DEG360) begin
                    hw = cand;
                end
            end
        end
        n_s1_h = hw[H_W-1:0];

        hue   = (i_data.mode == MODE_HLS) || (i_data.mode == MODE_HSL);
        l_raw = (i_data.mode == MODE_HSL) ? i_data.comp_c : i_data.comp_b;
        s_raw = (i_data.mode == MODE_HSL) ? i_data.comp_b : i_data.comp_c;
        n_s1_l = clamp_unit(l_raw);
        n_s1_s = clamp_unit(s_raw);

        // achromatic pixels leave as gray at the lightness
        n_s1_pass = !hue || (n_s1_s == '0);
        if (hue) begin
            n_s1_pv[0] = n_s1_l;
            n_s1_pv[1] = n_s1_l;
            n_s1_pv[2] = n_s1_l;
        end else begin
            n_s1_pv[0] = clamp_unit(i_data.comp_a);
            n_s1_pv[1] = clamp_unit(i_data.comp_b);
            n_s1_pv[2] = clamp_unit(i_data.comp_c);
        end
    end

    // stage 2: l*(1+s) or l*s, and the segment of each channel hue
    always_comb begin
        logic [V_W:0]            mult;
        logic signed [HC_W-1:0]  hc;
        n_s2_le = (r_s1_l <= V_W'(ONE_FX >>> 1));
        mult    = n_s2_le ? ((V_W + 1)'(ONE_FX) + (V_W + 1)'(r_s1_s))
                          : (V_W + 1)'(r_s1_s);
        n_s2_p  = P_W'(r_s1_l) * P_W'(mult);

        for (int c = 0; c < 3; c++) begin
            // red leads by 120 degrees, blue trails by 120
            if (c == 0) begin
                hc = HC_W'(r_s1_h) + HC_W'(DEG120);
            end else if (c == 1) begin
                hc = HC_W'(r_s1_h);
            end else begin
                hc = HC_W'(r_s1_h) - HC_W'(DEG120);
            end
            if (hc > DEG360) begin
                hc = hc - HC_W'(DEG360);
            end
            if (hc < 0) begin
                hc = hc + HC_W'(DEG360);
            end

            if (hc < DEG60) begin
                n_s2_seg[c] = SEG_RAMP;
                n_s2_dh[c]  = hc[DH_W-1:0];
            end else if (hc < DEG180) begin
                n_s2_seg[c] = SEG_HI;
                n_s2_dh[c]  = '0;
            end else if (hc < DEG240) begin
                n_s2_seg[c] = SEG_RAMP;
                n_s2_dh[c]  = DH_W'(HC_W'(DEG240) - hc);
            end else begin
                n_s2_seg[c] = SEG_LO;
                n_s2_dh[c]  = '0;
            end
        end
    end

    // stage 3: round the product, form m2, m1 and m2 - m1
    always_comb begin
        logic [P_W-1:0] psum;
        logic [V_W-1:0] rnd;
        logic [V_W:0]   hi;
        psum = r_s2_p + P_W'(ONE_FX >>> 1);
        rnd  = psum[FRAC_BITS +: V_W];
        hi   = (V_W + 1)'(r_s2_l) + (V_W + 1)'(r_s2_s) - (V_W + 1)'(rnd);
        n_s3_m2   = r_s2_le ? rnd : hi[V_W-1:0];
        n_s3_m1   = $signed(C_W'({r_s2_l, 1'b0})) - $signed(C_W'(n_s3_m2));
        n_s3_diff = DF_W'({n_s3_m2, 1'b0}) - DF_W'({r_s2_l, 1'b0});
    end

    // stage 5: round, drop the power of two part of 60 degrees, times 1/15
    always_comb begin
        logic [N_W:0]   nsum;
        logic [X_W-1:0] x;
        for (int c = 0; c < 3; c++) begin
            nsum         = (N_W + 1)'(r_s4_num[c]) + (N_W + 1)'(HALF60);
            x            = nsum[X_SH +: X_W];
            n_s5_prod[c] = PR_W'(x) * PR_W'(RCP_M);
        end
    end

    // stage 6: pick ramp, m2 or m1, then clamp
    always_comb begin
        logic [Q_W-1:0]        q;
        logic signed [C_W-1:0] ch;
        logic [V_W-1:0]        v [3];
        for (int c = 0; c < 3; c++) begin
            q = r_s5_prod[c][RCP_SH +: Q_W];
            case (r_s5_seg[c])
                SEG_RAMP: ch = r_s5_m1 + $signed(C_W'(q));
                SEG_HI:   ch = $signed(C_W'(r_s5_m2));
                SEG_LO:   ch = r_s5_m1;
                default:  ch = r_s5_m1;
            endcase
            v[c] = r_s5_pass ? r_s5_pv[c] : clamp_unit(IN_W'(ch));
        end
        n_out.red_out   = OUT_W'(v[0]);
        n_out.green_out = OUT_W'(v[1]);
        n_out.blue_out  = OUT_W'(v[2]);
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
            r_v6 <= 1'b0;
        end else begin
            if (w_en1) begin
                r_v1 <= i_valid;
            end
            if (w_en2) begin
                r_v2 <= r_v1;
            end
            if (w_en3) begin
                r_v3 <= r_v2;
            end
            if (w_en4) begin
                r_v4 <= r_v3;
            end
            if (w_en5) begin
                r_v5 <= r_v4;
            end
            if (w_en6) begin
                r_v6 <= r_v5;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (w_en1) begin
            r_s1_h    <= n_s1_h;
            r_s1_l    <= n_s1_l;
            r_s1_s    <= n_s1_s;
            r_s1_pass <= n_s1_pass;
            r_s1_pv   <= n_s1_pv;
        end
        if (w_en2) begin
            r_s2_p    <= n_s2_p;
            r_s2_le   <= n_s2_le;
            r_s2_l    <= r_s1_l;
            r_s2_s    <= r_s1_s;
            r_s2_seg  <= n_s2_seg;
            r_s2_dh   <= n_s2_dh;
            r_s2_pass <= r_s1_pass;
            r_s2_pv   <= r_s1_pv;
        end
        if (w_en3) begin
            r_s3_m1   <= n_s3_m1;
            r_s3_m2   <= n_s3_m2;
            r_s3_diff <= n_s3_diff;
            r_s3_seg  <= r_s2_seg;
            r_s3_dh   <= r_s2_dh;
            r_s3_pass <= r_s2_pass;
            r_s3_pv   <= r_s2_pv;
        end
        if (w_en4) begin
            for (int c = 0; c < 3; c++) begin
                r_s4_num[c] <= N_W'(r_s3_diff) * N_W'(r_s3_dh[c]);
            end
            r_s4_m1   <= r_s3_m1;
            r_s4_m2   <= r_s3_m2;
            r_s4_seg  <= r_s3_seg;
            r_s4_pass <= r_s3_pass;
            r_s4_pv   <= r_s3_pv;
        end
        if (w_en5) begin
            r_s5_prod <= n_s5_prod;
            r_s5_m1   <= r_s4_m1;
            r_s5_m2   <= r_s4_m2;
            r_s5_seg  <= r_s4_seg;
            r_s5_pass <= r_s4_pass;
            r_s5_pv   <= r_s4_pv;
        end
        if (w_en6) begin
            r_out <= n_out;
        end
    end

endmodule

### rtl/hrc_checker.sv
// port level checks of the hls to rgb converter, bound to the top level
module hrc_checker
    import hrc_pkg::*;
(
    input logic     i_clk,
    input logic     i_rst_n,
    input logic     i_valid,
    input logic     o_ready,
    input t_hrc_in  i_data,
    input logic     o_valid,
    input logic     i_ready,
    input t_hrc_out o_data
);

    localparam logic [OUT_W-1:0] OUT_MAX =
        (FRAC_BITS <= 12) ? OUT_W'(ONE_FX) : {OUT_W{1'b1}};

    // pipeline is empty after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid right after reset");

    // a ready sink never stalls the source
    a_no_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ready |-> o_ready)
        else $error("input stalled while output side is ready");

    // a stalled result stays offered and unchanged
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_data))
        else $error("stalled result dropped or changed");

    // every channel within 0..1.0
    a_out_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_data.red_out <= OUT_MAX) && (o_data.green_out <= OUT_MAX)
                    && (o_data.blue_out <= OUT_MAX))
        else $error("channel above full scale");

endmodule

bind hls_to_rgb_converter_core hrc_checker u_hrc_checker (.*);
